### rtl/esrp_pkg.sv
// ----------------------------------------------------------------------------
// esrp_pkg
// Shared types and constants of the shift-register EEPROM programmer.
// ----------------------------------------------------------------------------
`default_nettype none

package esrp_pkg;

  // Field widths of the stream items
  localparam int unsigned ADDRESS_BITS = 13;
  localparam int unsigned DATA_BITS    = 8;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned CFG_IDX_W    = 2;

  // Default number of program-and-verify attempts
  localparam int unsigned MAX_ATTEMPTS = 3;

  // Bit index covers the longer of the two serial runs
  localparam int unsigned BIT_IDX_W  = (ADDRESS_BITS > DATA_BITS) ?
                                       $clog2(ADDRESS_BITS) : $clog2(DATA_BITS);
  localparam int unsigned DATA_IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam int unsigned PHASE_W    = 4;
  localparam int unsigned ATTEMPT_W  = 2;

  // Stream packing
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_USED_W  = 10 + DATA_BITS;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_DELAY  = 2'd2;

  localparam logic [TICK_W-1:0] CLOCK_HIGH_RST  = 16'd1;
  localparam logic [TICK_W-1:0] WRITE_PULSE_RST = 16'd10;
  localparam logic [TICK_W-1:0] LOAD_DELAY_RST  = 16'd1;

  // Sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_PROG_HIGH = 4'd1;
  localparam logic [PHASE_W-1:0] PH_PROG_LOW  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_WPULSE    = 4'd3;
  localparam logic [PHASE_W-1:0] PH_ADDR_HIGH = 4'd4;
  localparam logic [PHASE_W-1:0] PH_ADDR_LOW  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_LOAD_PRE  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_LOAD_HIGH = 4'd7;
  localparam logic [PHASE_W-1:0] PH_LOAD_LOW  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_LOAD_POST = 4'd9;
  localparam logic [PHASE_W-1:0] PH_SAMP_HIGH = 4'd10;
  localparam logic [PHASE_W-1:0] PH_SAMP_LOW  = 4'd11;

  // Timing registers
  typedef struct packed {
    logic [TICK_W-1:0] clock_high;
    logic [TICK_W-1:0] write_pulse;
    logic [TICK_W-1:0] load_delay;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic [ADDRESS_BITS-1:0] address;
    logic [DATA_BITS-1:0]    data;
    logic                    serial_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic [DATA_BITS-1:0] rd_byte;
    logic                 success;
    logic                 done;
    logic                 busy;
    logic                 load_pin;
    logic                 write_enable_n;
    logic                 output_enable_n;
    logic                 chip_enable_n;
    logic                 data_out;
    logic                 address_out;
    logic                 clock_pin;
  } result_t;

endpackage

`default_nettype wire

### rtl/esrp_seq.sv
// ----------------------------------------------------------------------------
// esrp_seq
// Pin sequencer: state registers and the one-tick next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module esrp_seq #(
  parameter int unsigned MaxAttempts = esrp_pkg::MAX_ATTEMPTS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  wire esrp_pkg::item_t  item_i,
  input  wire esrp_pkg::cfg_t   cfg_i,
  output esrp_pkg::result_t     result_o
);

  localparam int unsigned AB = esrp_pkg::ADDRESS_BITS;
  localparam int unsigned DB = esrp_pkg::DATA_BITS;
  localparam int unsigned BW = esrp_pkg::BIT_IDX_W;
  localparam int unsigned DW = esrp_pkg::DATA_IDX_W;
  localparam int unsigned TW = esrp_pkg::TICK_W;
  localparam int unsigned AW = esrp_pkg::ATTEMPT_W;

  logic [esrp_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [BW-1:0]                bit_q, bit_d;
  logic [TW-1:0]                cnt_q, cnt_d;
  logic [AW-1:0]                att_q, att_d;
  logic                         is_wr_q, is_wr_d;
  logic [AB-1:0]                addr_q, addr_d;
  logic [DB-1:0]                dat_q, dat_d;
  logic [DB-1:0]                samp_q, samp_d;
  logic                         clk_pin_q, clk_pin_d;
  logic                         a_pin_q, a_pin_d;
  logic                         d_pin_q, d_pin_d;
  logic                         ce_q, ce_d;
  logic                         oe_q, oe_d;
  logic                         we_q, we_d;
  logic                         ld_q, ld_d;

  // Zero programmed counts behave as one
  logic [TW-1:0] span_ch, span_wp, span_ld;
  assign span_ch = (cfg_i.clock_high  == '0) ? TW'(1) : cfg_i.clock_high;
  assign span_wp = (cfg_i.write_pulse == '0) ? TW'(1) : cfg_i.write_pulse;
  assign span_ld = (cfg_i.load_delay  == '0) ? TW'(1) : cfg_i.load_delay;

  logic          done, succ, match;
  logic [BW-1:0] bit_nx;
  logic [AW-1:0] att_nx;
  logic [TW-1:0] cnt_inc;

  assign bit_nx  = bit_q + BW'(1);
  assign att_nx  = att_q + AW'(1);
  assign cnt_inc = cnt_q + TW'(1);
  assign match   = (samp_q == dat_q);

  // Next state for one tick
  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    att_d     = att_q;
    is_wr_d   = is_wr_q;
    addr_d    = addr_q;
    dat_d     = dat_q;
    samp_d    = samp_q;
    clk_pin_d = clk_pin_q;
    a_pin_d   = a_pin_q;
    d_pin_d   = d_pin_q;
    ce_d      = ce_q;
    oe_d      = oe_q;
    we_d      = we_q;
    ld_d      = ld_q;
    done      = 1'b0;
    succ      = 1'b0;

    case (phase_q)
      esrp_pkg::PH_IDLE: begin
        if (item_i.action == esrp_pkg::ACT_WRITE) begin
          is_wr_d   = 1'b1;
          addr_d    = item_i.address;
          dat_d     = item_i.data;
          att_d     = '0;
          bit_d     = '0;
          a_pin_d   = item_i.address[0];
          d_pin_d   = item_i.data[0];
          clk_pin_d = 1'b1;
          cnt_d     = TW'(1);
          phase_d   = esrp_pkg::PH_PROG_HIGH;
        end else if (item_i.action == esrp_pkg::ACT_READ) begin
          is_wr_d   = 1'b0;
          addr_d    = item_i.address;
          bit_d     = '0;
          a_pin_d   = item_i.address[0];
          clk_pin_d = 1'b1;
          cnt_d     = TW'(1);
          phase_d   = esrp_pkg::PH_ADDR_HIGH;
        end
      end
      esrp_pkg::PH_PROG_HIGH, esrp_pkg::PH_ADDR_HIGH, esrp_pkg::PH_SAMP_HIGH: begin
        if (cnt_q >= span_ch) begin
          clk_pin_d = 1'b0;
          phase_d   = phase_q + esrp_pkg::PHASE_W'(1);
        end else begin
          cnt_d = cnt_inc;
        end
      end
      esrp_pkg::PH_PROG_LOW: begin
        if (bit_q < BW'(AB - 1)) begin
          // next address bit, data alongside on the low bits
          bit_d     = bit_nx;
          a_pin_d   = addr_q[bit_nx];
          if (bit_nx < BW'(DB)) begin
            d_pin_d = dat_q[bit_nx[DW-1:0]];
          end
          clk_pin_d = 1'b1;
          cnt_d     = TW'(1);
          phase_d   = esrp_pkg::PH_PROG_HIGH;
        end else begin
          ce_d    = 1'b0;
          we_d    = 1'b0;
          cnt_d   = TW'(1);
          phase_d = esrp_pkg::PH_WPULSE;
        end
      end
      esrp_pkg::PH_WPULSE: begin
        if (cnt_q >= span_wp) begin
          we_d      = 1'b1;
          ce_d      = 1'b1;
          bit_d     = '0;
          a_pin_d   = addr_q[0];
          clk_pin_d = 1'b1;
          cnt_d     = TW'(1);
          phase_d   = esrp_pkg::PH_ADDR_HIGH;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      esrp_pkg::PH_ADDR_LOW: begin
        if (bit_q < BW'(AB - 1)) begin
          bit_d     = bit_nx;
          a_pin_d   = addr_q[bit_nx];
          clk_pin_d = 1'b1;
          cnt_d     = TW'(1);
          phase_d   = esrp_pkg::PH_ADDR_HIGH;
        end else begin
          ld_d    = 1'b1;
          ce_d    = 1'b0;
          oe_d    = 1'b0;
          cnt_d   = TW'(1);
          phase_d = esrp_pkg::PH_LOAD_PRE;
        end
      end
      esrp_pkg::PH_LOAD_PRE: begin
        if (cnt_q >= span_ld) begin
          clk_pin_d = 1'b1;
          cnt_d     = TW'(1);
          phase_d   = esrp_pkg::PH_LOAD_HIGH;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      esrp_pkg::PH_LOAD_HIGH: begin
        if (cnt_q >= span_ch) begin
          clk_pin_d = 1'b0;
          phase_d   = esrp_pkg::PH_LOAD_LOW;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      esrp_pkg::PH_LOAD_LOW: begin
        cnt_d   = TW'(1);
        phase_d = esrp_pkg::PH_LOAD_POST;
      end
      esrp_pkg::PH_LOAD_POST: begin
        if (cnt_q >= span_ld) begin
          // load ends, first sample taken with the first clock
          ld_d      = 1'b0;
          oe_d      = 1'b1;
          ce_d      = 1'b1;
          bit_d     = '0;
          samp_d[0] = item_i.serial_in;
          clk_pin_d = 1'b1;
          cnt_d     = TW'(1);
          phase_d   = esrp_pkg::PH_SAMP_HIGH;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      esrp_pkg::PH_SAMP_LOW: begin
        if (bit_q < BW'(DB - 1)) begin
          bit_d                 = bit_nx;
          samp_d[bit_nx[DW-1:0]] = item_i.serial_in;
          clk_pin_d             = 1'b1;
          cnt_d                 = TW'(1);
          phase_d               = esrp_pkg::PH_SAMP_HIGH;
        end else if (!is_wr_q) begin
          done    = 1'b1;
          succ    = 1'b1;
          phase_d = esrp_pkg::PH_IDLE;
        end else begin
          att_d = att_nx;
          if (match || (att_nx >= AW'(MaxAttempts))) begin
            done    = 1'b1;
            succ    = match;
            phase_d = esrp_pkg::PH_IDLE;
          end else begin
            // retry the whole program-and-verify cycle
            bit_d     = '0;
            a_pin_d   = addr_q[0];
            d_pin_d   = dat_q[0];
            clk_pin_d = 1'b1;
            cnt_d     = TW'(1);
            phase_d   = esrp_pkg::PH_PROG_HIGH;
          end
        end
      end
      default: begin
        phase_d = esrp_pkg::PH_IDLE;
      end
    endcase
  end

  // State advances once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= esrp_pkg::PH_IDLE;
      bit_q     <= '0;
      cnt_q     <= '0;
      att_q     <= '0;
      is_wr_q   <= 1'b0;
      addr_q    <= '0;
      dat_q     <= '0;
      samp_q    <= '0;
      clk_pin_q <= 1'b0;
      a_pin_q   <= 1'b0;
      d_pin_q   <= 1'b0;
      ce_q      <= 1'b1;
      oe_q      <= 1'b1;
      we_q      <= 1'b1;
      ld_q      <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      cnt_q     <= cnt_d;
      att_q     <= att_d;
      is_wr_q   <= is_wr_d;
      addr_q    <= addr_d;
      dat_q     <= dat_d;
      samp_q    <= samp_d;
      clk_pin_q <= clk_pin_d;
      a_pin_q   <= a_pin_d;
      d_pin_q   <= d_pin_d;
      ce_q      <= ce_d;
      oe_q      <= oe_d;
      we_q      <= we_d;
      ld_q      <= ld_d;
    end
  end

  // Result as it stands after the tick
  always_comb begin
    result_o.clock_pin       = clk_pin_d;
    result_o.address_out     = a_pin_d;
    result_o.data_out        = d_pin_d;
    result_o.chip_enable_n   = ce_d;
    result_o.output_enable_n = oe_d;
    result_o.write_enable_n  = we_d;
    result_o.load_pin        = ld_d;
    result_o.busy            = (phase_d != esrp_pkg::PH_IDLE);
    result_o.done            = done;
    result_o.success         = succ;
    result_o.rd_byte         = samp_d;
  end

endmodule

`default_nettype wire

### rtl/esrp_out.sv
// ----------------------------------------------------------------------------
// esrp_out
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module esrp_out (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     load_i,
  input  wire esrp_pkg::result_t  result_i,
  input  wire                     take_i,
  output logic                    valid_o,
  output esrp_pkg::result_t       result_o
);

  logic              valid_q;
  esrp_pkg::result_t res_q;

  // Valid flag: set on load, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### rtl/eeprom_shift_register_programmer.sv
// ----------------------------------------------------------------------------
// eeprom_shift_register_programmer
// Tick-driven pin sequencer that writes and reads an EEPROM through an
// external shift register.
// ----------------------------------------------------------------------------
// Usage:
//   Every transfer on the s_axis side is one tick of the pin sequence. It may
//   start a write or a read (taken only when idle) and carries the sampled
//   serial pin. Every tick gives exactly one transfer on the m_axis side with
//   all pin levels, busy, done, success and the last sampled byte.
//   The result of a tick is shown on m_axis the cycle after it is taken. One
//   tick is taken every cycle while results drain; the single result register
//   sets that figure.
//   When the receiver stalls, the result register holds and s_axis_tready
//   drops until it is taken, so the sequence simply pauses in tick time.
//   The user must write the timing registers over the cfg port only while idle; the block does not enforce it.
//   Reset puts the sequencer idle with enables high, clock, load and serial
//   lines low, and the timing registers at 1, 10 and 1 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module eeprom_shift_register_programmer #(
  parameter int unsigned MaxAttempts = esrp_pkg::MAX_ATTEMPTS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // action[1:0], address[14:2], data[22:15], serial_in[23]
  input  wire  [esrp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // clock_pin[0], address_out[1], data_out[2], chip_enable_n[3],
  // output_enable_n[4], write_enable_n[5], load_pin[6], busy_res[7],
  // done_res[8], success[9], rd_byte[17:10], zero[23:18]
  output logic [esrp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  input  wire                                  cfg_we_i,
  input  wire  [esrp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [esrp_pkg::TICK_W-1:0]          cfg_wdata_i
);

  localparam int unsigned AB = esrp_pkg::ADDRESS_BITS;
  localparam int unsigned DB = esrp_pkg::DATA_BITS;
  localparam int unsigned AW = esrp_pkg::ACTION_W;

  esrp_pkg::cfg_t    cfg_q;
  esrp_pkg::item_t   item;
  esrp_pkg::result_t res_d, res_q;
  logic              accept;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_high  <= esrp_pkg::CLOCK_HIGH_RST;
      cfg_q.write_pulse <= esrp_pkg::WRITE_PULSE_RST;
      cfg_q.load_delay  <= esrp_pkg::LOAD_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        esrp_pkg::CFG_CLOCK_HIGH:  cfg_q.clock_high  <= cfg_wdata_i;
        esrp_pkg::CFG_WRITE_PULSE: cfg_q.write_pulse <= cfg_wdata_i;
        esrp_pkg::CFG_LOAD_DELAY:  cfg_q.load_delay  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the input transfer
  assign item.action    = s_axis_tdata[AW-1:0];
  assign item.address   = s_axis_tdata[AW+AB-1:AW];
  assign item.data      = s_axis_tdata[AW+AB+DB-1:AW+AB];
  assign item.serial_in = s_axis_tdata[AW+AB+DB];

  // Take a tick whenever the result register is free or being emptied
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  esrp_seq #(
    .MaxAttempts (MaxAttempts)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  esrp_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (res_d),
    .take_i   (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .result_o (res_q)
  );

  // Pack the result transfer
  assign m_axis_tdata = {(esrp_pkg::OUT_TDATA_W - esrp_pkg::OUT_USED_W)'(0), res_q};

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the shift-register EEPROM programmer. A queue of
// ticks, built by an initial block, feeds a bursty driver. A cycle-true model
// of the pin sequencer predicts one result per accepted tick, and a monitor
// with its own back-pressure pattern compares every field of each result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time CLOCK_CYCLE = 8ns;
  localparam int  CYCLE_LIMIT = 4_000_000;

  // Action code the block must ignore, and the unused register slot
  localparam logic [esrp_pkg::ACTION_W-1:0]  ACT_UNDEF  = 2'd3;
  localparam logic [esrp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // How the serial pin answers a verify read-back
  localparam int BIAS_MATCH = 0;
  localparam int BIAS_MISS  = 1;
  localparam int BIAS_MIX   = 2;

  // Model of the sequencer state and pin levels
  typedef struct packed {
    logic [esrp_pkg::PHASE_W-1:0]      phase;
    logic [3:0]                        bit_idx;
    logic [esrp_pkg::TICK_W-1:0]       ticks;
    logic [esrp_pkg::ATTEMPT_W-1:0]    tries;
    logic                              is_write;
    logic [esrp_pkg::ADDRESS_BITS-1:0] addr;
    logic [esrp_pkg::DATA_BITS-1:0]    wbyte;
    logic [esrp_pkg::DATA_BITS-1:0]    rbyte;
    logic                              shift_clk;
    logic                              addr_line;
    logic                              data_line;
    logic                              ce_n;
    logic                              oe_n;
    logic                              we_n;
    logic                              load_line;
  } seq_state_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic [esrp_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [esrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [esrp_pkg::CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [esrp_pkg::TICK_W-1:0]      cfg_wdata_i   = '0;

  esrp_pkg::cfg_t    timing;
  seq_state_t        plan;     // advanced as ticks are generated
  seq_state_t        chk;      // advanced as ticks are accepted
  esrp_pkg::item_t   tick_q[$];
  esrp_pkg::result_t due_results[$];
  esrp_pkg::item_t   on_bus;
  int         pending_ticks = 0;
  int         failures      = 0;
  int         cycles        = 0;
  int         burst_left;
  int         gap_left;
  logic [15:0] ready_pat;
  int         pat_age;
  logic [esrp_pkg::DATA_BITS-1:0] verify_byte = '0;
  int         verify_bias = BIAS_MIX;
  int         busy_act    = -1;

  eeprom_shift_register_programmer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(CLOCK_CYCLE / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  function automatic seq_state_t idle_state();
    seq_state_t st;
    st      = '0;
    st.phase = esrp_pkg::PH_IDLE;
    st.ce_n = 1'b1;
    st.oe_n = 1'b1;
    st.we_n = 1'b1;
    return st;
  endfunction

  // True once a timed phase has run its length; a zero length counts as one
  function automatic bit period_over(inout seq_state_t st,
                                     input logic [esrp_pkg::TICK_W-1:0] len);
    logic [esrp_pkg::TICK_W-1:0] reach;
    reach = (len == '0) ? 16'd1 : len;
    if (st.ticks >= reach) return 1'b1;
    st.ticks = st.ticks + 16'd1;
    return 1'b0;
  endfunction

  // Clock out one bit of the program run: address always, data for low bits
  function automatic void shift_prog_bit(inout seq_state_t st, input logic [3:0] i);
    st.bit_idx   = i;
    st.addr_line = st.addr[i];
    if (i < esrp_pkg::DATA_BITS) st.data_line = st.wbyte[i[2:0]];
    st.shift_clk = 1'b1;
    st.ticks     = 16'd1;
    st.phase     = esrp_pkg::PH_PROG_HIGH;
  endfunction

  function automatic void shift_addr_bit(inout seq_state_t st, input logic [3:0] i);
    st.bit_idx   = i;
    st.addr_line = st.addr[i];
    st.shift_clk = 1'b1;
    st.ticks     = 16'd1;
    st.phase     = esrp_pkg::PH_ADDR_HIGH;
  endfunction

  // Serial pin is captured as the sample clock rises
  function automatic void take_sample(inout seq_state_t st, input logic [3:0] i,
                                      input logic sin);
    st.bit_idx         = i;
    st.rbyte[i[2:0]]   = sin;
    st.shift_clk       = 1'b1;
    st.ticks           = 16'd1;
    st.phase           = esrp_pkg::PH_SAMP_HIGH;
  endfunction

  // One tick of the sequencer; returns the pin and status levels after it
  function automatic esrp_pkg::result_t step_sequencer(inout seq_state_t st,
                                                       input esrp_pkg::cfg_t c,
                                                       input esrp_pkg::item_t it);
    esrp_pkg::result_t r;
    logic              match;
    r = '0;
    case (st.phase)
      esrp_pkg::PH_IDLE: begin
        if (it.action == esrp_pkg::ACT_WRITE) begin
          st.is_write = 1'b1;
          st.addr     = it.address;
          st.wbyte    = it.data;
          st.tries    = '0;
          shift_prog_bit(st, 4'd0);
        end else if (it.action == esrp_pkg::ACT_READ) begin
          st.is_write = 1'b0;
          st.addr     = it.address;
          shift_addr_bit(st, 4'd0);
        end
      end
      esrp_pkg::PH_PROG_HIGH: begin
        if (period_over(st, c.clock_high)) begin
          st.shift_clk = 1'b0;
          st.phase     = esrp_pkg::PH_PROG_LOW;
        end
      end
      esrp_pkg::PH_PROG_LOW: begin
        if (st.bit_idx + 1 < esrp_pkg::ADDRESS_BITS) begin
          shift_prog_bit(st, st.bit_idx + 4'd1);
        end else begin
          st.ce_n  = 1'b0;
          st.we_n  = 1'b0;
          st.ticks = 16'd1;
          st.phase = esrp_pkg::PH_WPULSE;
        end
      end
      esrp_pkg::PH_WPULSE: begin
        if (period_over(st, c.write_pulse)) begin
          st.we_n = 1'b1;
          st.ce_n = 1'b1;
          shift_addr_bit(st, 4'd0);
        end
      end
      esrp_pkg::PH_ADDR_HIGH: begin
        if (period_over(st, c.clock_high)) begin
          st.shift_clk = 1'b0;
          st.phase     = esrp_pkg::PH_ADDR_LOW;
        end
      end
      esrp_pkg::PH_ADDR_LOW: begin
        if (st.bit_idx + 1 < esrp_pkg::ADDRESS_BITS) begin
          shift_addr_bit(st, st.bit_idx + 4'd1);
        end else begin
          st.load_line = 1'b1;
          st.ce_n      = 1'b0;
          st.oe_n      = 1'b0;
          st.ticks     = 16'd1;
          st.phase     = esrp_pkg::PH_LOAD_PRE;
        end
      end
      esrp_pkg::PH_LOAD_PRE: begin
        if (period_over(st, c.load_delay)) begin
          st.shift_clk = 1'b1;
          st.ticks     = 16'd1;
          st.phase     = esrp_pkg::PH_LOAD_HIGH;
        end
      end
      esrp_pkg::PH_LOAD_HIGH: begin
        if (period_over(st, c.clock_high)) begin
          st.shift_clk = 1'b0;
          st.phase     = esrp_pkg::PH_LOAD_LOW;
        end
      end
      esrp_pkg::PH_LOAD_LOW: begin
        st.ticks = 16'd1;
        st.phase = esrp_pkg::PH_LOAD_POST;
      end
      esrp_pkg::PH_LOAD_POST: begin
        if (period_over(st, c.load_delay)) begin
          st.load_line = 1'b0;
          st.oe_n      = 1'b1;
          st.ce_n      = 1'b1;
          take_sample(st, 4'd0, it.serial_in);
        end
      end
      esrp_pkg::PH_SAMP_HIGH: begin
        if (period_over(st, c.clock_high)) begin
          st.shift_clk = 1'b0;
          st.phase     = esrp_pkg::PH_SAMP_LOW;
        end
      end
      esrp_pkg::PH_SAMP_LOW: begin
        if (st.bit_idx + 1 < esrp_pkg::DATA_BITS) begin
          take_sample(st, st.bit_idx + 4'd1, it.serial_in);
        end else if (!st.is_write) begin
          r.done    = 1'b1;
          r.success = 1'b1;
          st.phase  = esrp_pkg::PH_IDLE;
        end else begin
          // verify: retry the whole program cycle until match or out of tries
          match    = (st.rbyte == st.wbyte);
          st.tries = st.tries + 2'd1;
          if (match || st.tries >= esrp_pkg::MAX_ATTEMPTS) begin
            r.done    = 1'b1;
            r.success = match;
            st.phase  = esrp_pkg::PH_IDLE;
          end else begin
            shift_prog_bit(st, 4'd0);
          end
        end
      end
      default: st.phase = esrp_pkg::PH_IDLE;
    endcase
    r.clock_pin       = st.shift_clk;
    r.address_out     = st.addr_line;
    r.data_out        = st.data_line;
    r.chip_enable_n   = st.ce_n;
    r.output_enable_n = st.oe_n;
    r.write_enable_n  = st.we_n;
    r.load_pin        = st.load_line;
    r.busy            = (st.phase != esrp_pkg::PH_IDLE);
    r.rd_byte         = st.rbyte;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tick generation
  // --------------------------------------------------------------------------
  task automatic put_tick(input logic [esrp_pkg::ACTION_W-1:0] act,
                          input logic [esrp_pkg::ADDRESS_BITS-1:0] addr,
                          input logic [esrp_pkg::DATA_BITS-1:0] dat, input logic sin);
    esrp_pkg::item_t it;
    it.action    = act;
    it.address   = addr;
    it.data      = dat;
    it.serial_in = sin;
    void'(step_sequencer(plan, timing, it));
    tick_q.push_back(it);
    pending_ticks++;
  endtask

  // Random tick; the serial pin follows the chosen read-back byte when sampled
  task automatic gen_tick(input int start_pct);
    logic [esrp_pkg::ACTION_W-1:0] act;
    logic                          sin;
    int                            pick;
    pick = $urandom_range(0, 99);
    sin  = 1'($urandom);
    if (plan.phase == esrp_pkg::PH_IDLE) begin
      if (pick < start_pct)
        act = ($urandom_range(0, 1) == 1) ? esrp_pkg::ACT_WRITE : esrp_pkg::ACT_READ;
      else if (pick < start_pct + 10) act = ACT_UNDEF;
      else act = esrp_pkg::ACT_NONE;
    end else if (busy_act >= 0) begin
      act = busy_act[esrp_pkg::ACTION_W-1:0];
    end else begin
      act = (pick < 20) ? esrp_pkg::ACTION_W'($urandom) : esrp_pkg::ACT_NONE;
    end
    // pick the byte the shift register will present on this attempt
    if (plan.phase == esrp_pkg::PH_LOAD_PRE) begin
      pick = $urandom_range(0, 99);
      if (!plan.is_write) verify_byte = esrp_pkg::DATA_BITS'($urandom);
      else if (verify_bias == BIAS_MATCH || (verify_bias == BIAS_MIX && pick < 45))
        verify_byte = plan.wbyte;
      else if (verify_bias == BIAS_MISS || pick < 80)
        verify_byte = plan.wbyte ^ (8'd1 << $urandom_range(0, 7));
      else verify_byte = esrp_pkg::DATA_BITS'($urandom);
    end
    if (plan.phase == esrp_pkg::PH_LOAD_POST) sin = verify_byte[0];
    else if (plan.phase == esrp_pkg::PH_SAMP_LOW && plan.bit_idx < esrp_pkg::DATA_BITS - 1)
      sin = verify_byte[plan.bit_idx[2:0] + 3'd1];
    put_tick(act, esrp_pkg::ADDRESS_BITS'($urandom), esrp_pkg::DATA_BITS'($urandom), sin);
  endtask

  // Tick on until the planned sequence is back at idle
  task automatic run_out();
    while (plan.phase != esrp_pkg::PH_IDLE) gen_tick(0);
  endtask

  task automatic wait_drained();
    while (pending_ticks != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [esrp_pkg::CFG_IDX_W-1:0] idx,
                         input logic [esrp_pkg::TICK_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      esrp_pkg::CFG_CLOCK_HIGH:  timing.clock_high  = val;
      esrp_pkg::CFG_WRITE_PULSE: timing.write_pulse = val;
      esrp_pkg::CFG_LOAD_DELAY:  timing.load_delay  = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reprogram the timing once idle, then run random ticks with a pause midway
  task automatic run_phase(input logic [esrp_pkg::TICK_W-1:0] ch,
                           input logic [esrp_pkg::TICK_W-1:0] wp,
                           input logic [esrp_pkg::TICK_W-1:0] ld, input int n_ticks,
                           input int start_pct);
    wait_drained();
    set_reg(esrp_pkg::CFG_CLOCK_HIGH, ch);
    set_reg(esrp_pkg::CFG_WRITE_PULSE, wp);
    set_reg(esrp_pkg::CFG_LOAD_DELAY, ld);
    for (int k = 0; k < n_ticks; k++) begin
      if (k == n_ticks / 2) wait_drained();
      gen_tick(start_pct);
    end
    run_out();
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(step_sequencer(chk, timing, on_bus));
        pending_ticks--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          on_bus = tick_q.pop_front();
          s_axis_tdata  <= {on_bus.serial_in, on_bus.data, on_bus.address, on_bus.action};
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: rotating ready pattern, field-by-field compare
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : mon
    esrp_pkg::result_t got;
    esrp_pkg::result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_pat = 16'hFFFF;
      pat_age   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = esrp_pkg::result_t'(m_axis_tdata[esrp_pkg::OUT_USED_W-1:0]);
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("clock_pin", want.clock_pin, got.clock_pin);
          check_field("address_out", want.address_out, got.address_out);
          check_field("data_out", want.data_out, got.data_out);
          check_field("chip_enable_n", want.chip_enable_n, got.chip_enable_n);
          check_field("output_enable_n", want.output_enable_n, got.output_enable_n);
          check_field("write_enable_n", want.write_enable_n, got.write_enable_n);
          check_field("load_pin", want.load_pin, got.load_pin);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("success", want.success, got.success);
          check_field("sampled byte", want.rd_byte, got.rd_byte);
          check_field("tdata padding", 0,
                      m_axis_tdata[esrp_pkg::OUT_TDATA_W-1:esrp_pkg::OUT_USED_W]);
        end
      end
      // new stall pattern now and then; a quarter of them never stall
      if (pat_age == 0) begin
        pat_age   = 63;
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h5555);
      end else begin
        pat_age--;
      end
      m_axis_tready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    timing.clock_high  = esrp_pkg::CLOCK_HIGH_RST;
    timing.write_pulse = esrp_pkg::WRITE_PULSE_RST;
    timing.load_delay  = esrp_pkg::LOAD_DELAY_RST;
    plan = idle_state();
    chk  = idle_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, ignored actions, clean and failing verify
    verify_bias = BIAS_MATCH;
    busy_act    = esrp_pkg::ACT_READ;
    put_tick(esrp_pkg::ACT_NONE, 13'h0000, 8'h00, 1'b0);
    put_tick(ACT_UNDEF, 13'h1FFF, 8'hFF, 1'b1);
    put_tick(esrp_pkg::ACT_WRITE, 13'h1FFF, 8'hFF, 1'b0);
    run_out();
    verify_bias = BIAS_MISS;
    busy_act    = esrp_pkg::ACT_WRITE;
    put_tick(esrp_pkg::ACT_WRITE, 13'h0000, 8'h00, 1'b1);
    run_out();
    busy_act = ACT_UNDEF;
    put_tick(esrp_pkg::ACT_READ, 13'h1555, 8'hAA, 1'b1);
    run_out();
    busy_act    = -1;
    verify_bias = BIAS_MIX;
    put_tick(esrp_pkg::ACT_READ, 13'h0AAA, 8'h55, 1'b0);
    run_out();
    put_tick(esrp_pkg::ACT_NONE, 13'h1FFF, 8'h00, 1'b1);

    // Random phases over several timing settings; zero acts as one tick
    run_phase(16'd0, 16'd0, 16'd0, 60, 30);
    run_phase(16'd1, 16'd1, 16'd1, 60, 30);
    run_phase(16'd3, 16'd17, 16'd2, 60, 30);

    // Long write pulse, one verified write
    run_phase(16'd2, 16'd40, 16'd1, 0, 0);
    verify_bias = BIAS_MATCH;
    put_tick(esrp_pkg::ACT_WRITE, esrp_pkg::ADDRESS_BITS'($urandom),
             esrp_pkg::DATA_BITS'($urandom), 1'b0);
    run_out();

    // Long load delay, one read
    run_phase(16'd1, 16'd5, 16'd20, 0, 0);
    put_tick(esrp_pkg::ACT_READ, esrp_pkg::ADDRESS_BITS'($urandom),
             esrp_pkg::DATA_BITS'($urandom), 1'b1);
    run_out();

    // Slow shift clock, one write with retries possible and one read
    run_phase(16'd3, 16'd20, 16'd5, 0, 0);
    verify_bias = BIAS_MIX;
    put_tick(esrp_pkg::ACT_WRITE, esrp_pkg::ADDRESS_BITS'($urandom),
             esrp_pkg::DATA_BITS'($urandom), 1'b0);
    run_out();
    put_tick(esrp_pkg::ACT_READ, esrp_pkg::ADDRESS_BITS'($urandom),
             esrp_pkg::DATA_BITS'($urandom), 1'b0);
    run_out();

    // Largest clock high time, idle ticks only
    run_phase(16'hFFFF, 16'd3, 16'd3, 40, 0);

    // Write to the unused register slot must change nothing
    wait_drained();
    set_reg(CFG_UNUSED, 16'hFFFF);
    run_phase(esrp_pkg::CLOCK_HIGH_RST, esrp_pkg::WRITE_PULSE_RST,
              esrp_pkg::LOAD_DELAY_RST, 100, 30);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/esrp_pkg.sv
rtl/esrp_seq.sv
rtl/esrp_out.sv
rtl/eeprom_shift_register_programmer.sv
tb/tb_top.sv
